[hdl/pwfd_pkg.sv]
// Shared types, constants and the CRC step for the pulse width frame decoder.
// Used by pwfd_buf and pulse_width_frame_decoder; depends on nothing.
package pwfd_pkg;

  localparam int BUFFER_BYTES_DEF = 64;
  localparam int NUM_REGS         = 8;
  localparam int REG_IDX_W        = 3;
  localparam int BOUND_W          = 16;
  localparam int TIME_W           = 32;
  localparam int CNT_W            = 32;
  localparam int WORD_W           = 16;
  localparam int NUM_WORDS        = 5;
  localparam int WORD_BASE        = 4;
  localparam int MIRROR_BYTES     = 2 * NUM_WORDS;
  localparam int MIRROR_IDX_W     = 4;
  localparam int STATUS_W         = 2;

  localparam logic [7:0] CRC_POLY_HALF = 8'h18;

  // Register map of the configuration port
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ZERO_LO = 3'd0,
    REG_ZERO_HI = 3'd1,
    REG_ONE_LO  = 3'd2,
    REG_ONE_HI  = 3'd3,
    REG_SYNC_LO = 3'd4,
    REG_SYNC_HI = 3'd5,
    REG_END_LO  = 3'd6,
    REG_END_HI  = 3'd7
  } reg_idx_t;

  localparam logic [BOUND_W-1:0] BOUND_RESET [NUM_REGS] = '{
    16'd200, 16'd400, 16'd500, 16'd700, 16'd1900, 16'd2100, 16'd2900, 16'd3100
  };

  // Frame status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED   = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_CRC_FAIL   = 2'd2
  } status_t;

  // Request from the decoder to the frame buffer
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [7:0] wr_data;
  } buf_req_t;

  // One bit of the reflected CRC-8 (x^8+x^5+x^4+1)
  function automatic logic [7:0] crc_bit(input logic [7:0] c, input logic b);
    logic       fb;
    logic [7:0] x;
    fb = c[0] ^ b;
    x  = fb ? (c ^ CRC_POLY_HALF) : c;
    return {fb, x[7:1]};
  endfunction

endpackage

[hdl/pwfd_buf.sv]
// Frame byte buffer: synchronous-read memory with per-entry valid bits
// and write-to-read forwarding. Depends on pwfd_pkg.
module pwfd_buf #(
  parameter int DEPTH = pwfd_pkg::BUFFER_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pwfd_pkg::buf_req_t       req,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  output logic [7:0]               rd_byte
);
  import pwfd_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic          vld_r [DEPTH];
  logic [7:0]    rd_data_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_addr_r;
  logic          lw_v_r;
  logic [AW-1:0] lw_addr_r;
  logic [7:0]    lw_data_r;

  // Memory array: write one byte, read one byte, read data registered
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // Hold the latest write for forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_v_r <= 1'b0;
    end else if (req.wr_en) begin
      lw_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      lw_addr_r <= wr_addr;
      lw_data_r <= req.wr_data;
    end
  end

  // Forward the latest write when it hits the address just read
  always_comb begin
    if (lw_v_r && (lw_addr_r == rd_addr_r)) begin
      rd_byte = lw_data_r;
    end else if (rd_vld_r) begin
      rd_byte = rd_data_r;
    end else begin
      rd_byte = 8'h00;
    end
  end

endmodule

[hdl/pulse_width_frame_decoder.sv]
// Pulse width frame decoder top level: edge classification, bit and byte
// assembly, CRC check and word extraction. Depends on pwfd_pkg and pwfd_buf.
//
// Usage:
//   Input channel (in_valid/in_ready): one pin edge per transfer, with the
//   level after the edge and a microsecond timestamp. Falling edges store the
//   time; rising edges measure the low width and classify it as zero bit,
//   one bit, sync or frame end, using eight 16-bit exclusive bounds written
//   through cfg_we/cfg_index/cfg_data while the block is idle.
//   Output channel (out_valid/out_ready): one result per frame end, with the
//   frame status, the three wrapping counters and the five decoded words.
//   Pipeline: a frame end passes the check stage (buffer read and CRC
//   compare), then the output register. Throughput: one edge per cycle
//   unless stalled. The frame buffer is a one-port-read, one-port-write
//   memory; a bit is merged into its byte by read-modify-write with
//   forwarding, so back-to-back edges to one byte need no wait.
//   Stall: while a result waits in the output register, one more frame end
//   can finish its check; in_ready drops only when that frame end is also
//   held, and rises again the cycle the receiver takes the waiting result.
//   Reset: synchronous; bounds return to their defaults, counters, positions,
//   CRC and words clear, and the buffer valid bits clear at once, so no
//   clearing pass is needed.
module pulse_width_frame_decoder #(
  parameter int BUFFER_BYTES = pwfd_pkg::BUFFER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [pwfd_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [pwfd_pkg::BOUND_W-1:0]     cfg_data,
  // edge input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_pin_level,
  input  logic [pwfd_pkg::TIME_W-1:0]      in_edge_time,
  // frame results
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pwfd_pkg::STATUS_W-1:0]    out_frame_status,
  output logic [pwfd_pkg::CNT_W-1:0]       out_frames_seen,
  output logic [pwfd_pkg::CNT_W-1:0]       out_incomplete_seen,
  output logic [pwfd_pkg::CNT_W-1:0]       out_crc_failures,
  output logic signed [pwfd_pkg::WORD_W-1:0] out_word_one,
  output logic signed [pwfd_pkg::WORD_W-1:0] out_word_two,
  output logic signed [pwfd_pkg::WORD_W-1:0] out_word_three,
  output logic signed [pwfd_pkg::WORD_W-1:0] out_word_four,
  output logic signed [pwfd_pkg::WORD_W-1:0] out_word_five
);
  import pwfd_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam logic [PW-1:0] FULL_POS  = PW'(BUFFER_BYTES);
  localparam logic [PW-1:0] MIR_FIRST = PW'(WORD_BASE);
  localparam logic [PW-1:0] MIR_LAST  = PW'(WORD_BASE + MIRROR_BYTES - 1);

  function automatic logic in_win(input logic [TIME_W-1:0] w,
                                  input logic [BOUND_W-1:0] lo,
                                  input logic [BOUND_W-1:0] hi);
    return (w > TIME_W'(lo)) && (w < TIME_W'(hi));
  endfunction

  // Configuration and front-end state
  logic [BOUND_W-1:0] bnd_r [NUM_REGS];
  logic [TIME_W-1:0]  fall_time_r;
  logic [2:0]         bit_pos_r;
  logic [PW-1:0]      byte_pos_r;
  logic [7:0]         crc_r;
  logic [7:0]         cbl_r;
  logic [CNT_W-1:0]   frames_r;
  logic [CNT_W-1:0]   partials_r;
  logic [CNT_W-1:0]   mismatch_r;
  logic [7:0]         mir_r [MIRROR_BYTES];
  logic [WORD_W-1:0]  words_r [NUM_WORDS];

  // Check stage
  logic               s1_v_r;
  logic               s1_end_r;
  logic               s1_bit_r;
  logic [2:0]         s1_bitpos_r;
  logic [AW-1:0]      s1_addr_r;
  logic               s1_partial_r;
  logic [7:0]         s1_cbl_r;
  logic [CNT_W-1:0]   s1_frames_r;
  logic [CNT_W-1:0]   s1_partials_r;

  // Output register
  logic               out_valid_r;
  status_t            out_status_r;
  logic [CNT_W-1:0]   out_frames_r;
  logic [CNT_W-1:0]   out_partials_r;

  logic               in_fire;
  logic [TIME_W-1:0]  width;
  logic               win_zero, win_one, win_sync, win_end;
  logic               is_bit, bit_val, take, is_sync, is_end, frame_partial;
  logic [PW-1:0]      last_pos;
  logic [PW-1:0]      mir_off;
  logic [MIRROR_IDX_W-1:0] mir_idx;
  logic               mir_hit;
  logic               s1_adv;
  buf_req_t           req;
  logic [AW-1:0]      rd_addr;
  logic [7:0]         rd_byte;
  logic [7:0]         merged;
  status_t            s1_status;

  // Classify the rising edge by low width; first match wins
  assign width    = in_edge_time - fall_time_r;
  assign win_zero = in_win(width, bnd_r[REG_ZERO_LO], bnd_r[REG_ZERO_HI]);
  assign win_one  = in_win(width, bnd_r[REG_ONE_LO],  bnd_r[REG_ONE_HI]);
  assign win_sync = in_win(width, bnd_r[REG_SYNC_LO], bnd_r[REG_SYNC_HI]);
  assign win_end  = in_win(width, bnd_r[REG_END_LO],  bnd_r[REG_END_HI]);

  assign is_bit  = in_pin_level && (win_zero || win_one);
  assign bit_val = !win_zero;
  assign take    = is_bit && (byte_pos_r < FULL_POS);
  assign is_sync = in_pin_level && !win_zero && !win_one && win_sync;
  assign is_end  = in_pin_level && !win_zero && !win_one && !win_sync && win_end;
  assign frame_partial = (bit_pos_r != 3'd0) || (byte_pos_r == '0);

  assign last_pos = byte_pos_r - PW'(1);
  assign mir_off  = byte_pos_r - MIR_FIRST;
  assign mir_idx  = mir_off[MIRROR_IDX_W-1:0];
  assign mir_hit  = (byte_pos_r >= MIR_FIRST) && (byte_pos_r <= MIR_LAST);

  // Advance the check stage unless its frame end has nowhere to go
  assign s1_adv   = !s1_v_r || !s1_end_r || !out_valid_r || out_ready;
  assign in_ready = s1_adv;
  assign in_fire  = in_valid && in_ready;

  // Drive the buffer: read at accept, write the merged byte from the check stage
  assign rd_addr     = take ? byte_pos_r[AW-1:0] : last_pos[AW-1:0];
  assign req.rd_en   = in_fire && (take || is_end);
  assign req.wr_en   = s1_v_r && !s1_end_r;
  assign req.wr_data = merged;

  always_comb begin
    merged = rd_byte;
    merged[s1_bitpos_r] = s1_bit_r;
  end

  pwfd_buf #(
    .DEPTH (BUFFER_BYTES)
  ) u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_addr (rd_addr),
    .wr_addr (s1_addr_r),
    .rd_byte (rd_byte)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        bnd_r[i] <= BOUND_RESET[i];
      end
    end else if (cfg_we) begin
      bnd_r[cfg_index] <= cfg_data;
    end
  end

  // Front-end state: fall time, positions, CRC, frame counters, word bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_time_r <= '0;
      bit_pos_r   <= '0;
      byte_pos_r  <= '0;
      crc_r       <= '0;
      cbl_r       <= '0;
      frames_r    <= '0;
      partials_r  <= '0;
      for (int i = 0; i < MIRROR_BYTES; i++) begin
        mir_r[i] <= '0;
      end
    end else if (in_fire) begin
      if (!in_pin_level) begin
        fall_time_r <= in_edge_time;
      end
      if (take) begin
        if (bit_pos_r == 3'd0) begin
          cbl_r <= crc_r;
        end
        crc_r     <= crc_bit(crc_r, bit_val);
        bit_pos_r <= bit_pos_r + 3'd1;
        if (bit_pos_r == 3'd7) begin
          byte_pos_r <= byte_pos_r + PW'(1);
        end
        if (mir_hit) begin
          mir_r[mir_idx][bit_pos_r] <= bit_val;
        end
      end
      if (is_sync) begin
        bit_pos_r  <= '0;
        byte_pos_r <= '0;
        crc_r      <= '0;
      end
      if (is_end) begin
        frames_r <= frames_r + CNT_W'(1);
        if (frame_partial) begin
          partials_r <= partials_r + CNT_W'(1);
        end
      end
    end
  end

  // Check stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_fire && (take || is_end);
    end
  end

  // Check stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_end_r      <= is_end;
      s1_bit_r      <= bit_val;
      s1_bitpos_r   <= bit_pos_r;
      s1_addr_r     <= rd_addr;
      s1_partial_r  <= frame_partial;
      s1_cbl_r      <= cbl_r;
      s1_frames_r   <= frames_r + CNT_W'(1);
      s1_partials_r <= partials_r + (frame_partial ? CNT_W'(1) : CNT_W'(0));
    end
  end

  // Compare the last byte against the CRC of the bytes before it
  always_comb begin
    if (s1_partial_r) begin
      s1_status = ST_INCOMPLETE;
    end else if (rd_byte != s1_cbl_r) begin
      s1_status = ST_CRC_FAIL;
    end else begin
      s1_status = ST_ACCEPTED;
    end
  end

  // Result state: mismatch counter, decoded words, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mismatch_r  <= '0;
      for (int k = 0; k < NUM_WORDS; k++) begin
        words_r[k] <= '0;
      end
    end else begin
      if (s1_v_r && s1_end_r && s1_adv) begin
        out_valid_r <= 1'b1;
        if (s1_status == ST_CRC_FAIL) begin
          mismatch_r <= mismatch_r + CNT_W'(1);
        end
        if (s1_status == ST_ACCEPTED) begin
          for (int k = 0; k < NUM_WORDS; k++) begin
            words_r[k] <= {mir_r[2*k], mir_r[2*k+1]};
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_end_r && s1_adv) begin
      out_status_r   <= s1_status;
      out_frames_r   <= s1_frames_r;
      out_partials_r <= s1_partials_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_status    = out_status_r;
  assign out_frames_seen     = out_frames_r;
  assign out_incomplete_seen = out_partials_r;
  assign out_crc_failures    = mismatch_r;
  assign out_word_one        = words_r[0];
  assign out_word_two        = words_r[1];
  assign out_word_three      = words_r[2];
  assign out_word_four       = words_r[3];
  assign out_word_five       = words_r[4];

  // Input stalls only behind a held frame end and a full output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && s1_end_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked frame end");

  // Byte position never passes the buffer size
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r <= FULL_POS)
    else $error("byte position beyond buffer");

  // A partial byte only exists while the buffer has room
  a_partial_room: assert property (@(posedge clk) disable iff (!rst_n)
    (bit_pos_r != 3'd0) |-> (byte_pos_r < FULL_POS))
    else $error("partial byte in a full buffer");

  // A checked frame end always lands in the output register
  a_end_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_end_r && s1_adv) |=> out_valid_r)
    else $error("frame end result lost");

endmodule

[tb/sv/tb_pulse_width_frame_decoder.sv]
// Self-checking testbench for pulse_width_frame_decoder: directed edge table, then
// random pulse-coded frames under several bound settings, checked by a local decoder model.
// Depends on pwfd_pkg and the pulse_width_frame_decoder RTL.
module tb_pulse_width_frame_decoder;
  import pwfd_pkg::*;

  localparam int BUF_BYTES = BUFFER_BYTES_DEF;

  // Pulse classes, in priority order; each owns a pair of bound registers
  typedef enum int {CLS_ZERO = 0, CLS_ONE = 1, CLS_SYNC = 2, CLS_END = 3} pulse_class_t;

  typedef enum int {ROW_PULSE, ROW_FALL, ROW_RISE, ROW_FRAME} row_kind_t;

  typedef enum int {
    SET_SPREAD, SET_OVERLAP, SET_WIDE, SET_ZEROS, SET_DEFAULT, SET_MAX
  } setting_t;

  typedef struct packed {
    status_t                 status;
    logic [CNT_W-1:0]        frames;
    logic [CNT_W-1:0]        partials;
    logic [CNT_W-1:0]        crc_bad;
    logic [4:0][WORD_W-1:0]  words;
  } frame_result_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [31:0]   t;
    logic [31:0]   w;
    int            n;
    bit            typed;
    frame_result_t res;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [REG_IDX_W-1:0]   cfg_index;
  logic [BOUND_W-1:0]     cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_pin_level;
  logic [TIME_W-1:0]      in_edge_time;
  logic                   out_valid;
  logic                   out_ready;
  logic [STATUS_W-1:0]    out_frame_status;
  logic [CNT_W-1:0]       out_frames_seen;
  logic [CNT_W-1:0]       out_incomplete_seen;
  logic [CNT_W-1:0]       out_crc_failures;
  logic signed [WORD_W-1:0] out_word_one;
  logic signed [WORD_W-1:0] out_word_two;
  logic signed [WORD_W-1:0] out_word_three;
  logic signed [WORD_W-1:0] out_word_four;
  logic signed [WORD_W-1:0] out_word_five;

  pulse_width_frame_decoder u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pin_level        (in_pin_level),
    .in_edge_time        (in_edge_time),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_status    (out_frame_status),
    .out_frames_seen     (out_frames_seen),
    .out_incomplete_seen (out_incomplete_seen),
    .out_crc_failures    (out_crc_failures),
    .out_word_one        (out_word_one),
    .out_word_two        (out_word_two),
    .out_word_three      (out_word_three),
    .out_word_four       (out_word_four),
    .out_word_five       (out_word_five)
  );

  always #6 clk = ~clk;

  // Decoder model state
  logic [BOUND_W-1:0]     bound [NUM_REGS];
  logic [31:0]            fall_us;
  logic [7:0]             frame_buf [BUF_BYTES];
  logic [2:0]             bit_idx;
  int                     byte_idx;
  logic [7:0]             crc_run;
  logic [7:0]             crc_prior;
  logic [CNT_W-1:0]       frames_total;
  logic [CNT_W-1:0]       partial_total;
  logic [CNT_W-1:0]       crc_bad_total;
  logic [4:0][WORD_W-1:0] words_held;

  frame_result_t frame_results_due [$];
  dir_row_t      dir_rows [$];
  logic [7:0]    frame_q [$];

  // Stimulus bookkeeping
  logic [31:0]   pin_clock;
  bit            steady;
  int            noise_pct;
  bit            typed_pending;
  frame_result_t typed_result;
  int            edges_sent;
  int            results_due_total;
  int            settings_used;
  int            fail_count;

  // One bit of the reflected Dallas/Maxim CRC-8
  function automatic logic [7:0] crc_step(input logic [7:0] c, input logic b);
    return (c[0] ^ b) ? ((c >> 1) ^ 8'h8C) : (c >> 1);
  endfunction

  function automatic bit in_class(input logic [31:0] w, input pulse_class_t cls);
    return w > bound[2 * int'(cls)] && w < bound[2 * int'(cls) + 1];
  endfunction

  // Merge one data bit into the frame buffer; drop it once the buffer is full
  function automatic void store_bit(input logic b);
    if (byte_idx >= BUF_BYTES) return;
    if (bit_idx == 3'd0) crc_prior = crc_run;
    frame_buf[byte_idx][bit_idx] = b;
    crc_run = crc_step(crc_run, b);
    bit_idx = bit_idx + 3'd1;
    if (bit_idx == 3'd0) byte_idx++;
  endfunction

  // Advance the decoder model by one pin edge
  function automatic void decode_edge(input logic lvl, input logic [31:0] t,
                                      output bit hit, output frame_result_t r);
    logic [31:0] w;
    hit = 1'b0;
    r = '0;
    if (!lvl) begin
      fall_us = t;
      return;
    end
    w = t - fall_us;
    if (in_class(w, CLS_ZERO)) begin
      store_bit(1'b0);
    end else if (in_class(w, CLS_ONE)) begin
      store_bit(1'b1);
    end else if (in_class(w, CLS_SYNC)) begin
      bit_idx = 3'd0;
      byte_idx = 0;
      crc_run = 8'h00;
    end else if (in_class(w, CLS_END)) begin
      hit = 1'b1;
      frames_total++;
      if (bit_idx != 3'd0 || byte_idx == 0) begin
        partial_total++;
        r.status = ST_INCOMPLETE;
      end else if (frame_buf[(byte_idx - 1) % BUF_BYTES] != crc_prior) begin
        crc_bad_total++;
        r.status = ST_CRC_FAIL;
      end else begin
        for (int k = 0; k < NUM_WORDS; k++)
          words_held[k] = {frame_buf[WORD_BASE + 2 * k], frame_buf[WORD_BASE + 2 * k + 1]};
        r.status = ST_ACCEPTED;
      end
      r.frames   = frames_total;
      r.partials = partial_total;
      r.crc_bad  = crc_bad_total;
      r.words    = words_held;
    end
  endfunction

  // Present one edge and hold it until the transfer; valid stays high on return
  task automatic send_edge(input logic lvl, input logic [31:0] t);
    bit            hit;
    frame_result_t r;
    @(negedge clk);
    while (!steady && $urandom_range(99, 0) < 33) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_pin_level = lvl;
    in_edge_time = t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_edge(lvl, t, hit, r);
    edges_sent++;
    if (hit) begin
      frame_results_due.push_back(typed_pending ? typed_result : r);
      typed_pending = 1'b0;
      results_due_total++;
    end
  endtask

  // Low pulse of width w starting at the pin clock, then a random high time
  task automatic send_pulse(input logic [31:0] w);
    send_edge(1'b0, pin_clock);
    send_edge(1'b1, pin_clock + w);
    pin_clock = pin_clock + w + $urandom_range(800, 20);
  endtask

  function automatic logic [31:0] noise_width();
    int idx;
    idx = $urandom_range(NUM_REGS - 1, 0);
    case ($urandom_range(3, 0))
      0:       return $urandom;
      1:       return $urandom_range(65535, 0);
      2:       return {16'h0, bound[idx]};
      default: return $urandom_range(1, 0) ? {16'h0, bound[idx]} + 32'd1
                                           : {16'h0, bound[idx]} - 32'd1;
    endcase
  endfunction

  // Pick a width inside the class window, often right at its edges; noise if the window is empty
  function automatic logic [31:0] class_width(input pulse_class_t cls);
    logic [31:0] lo, hi;
    int          p;
    lo = {16'h0, bound[2 * int'(cls)]};
    hi = {16'h0, bound[2 * int'(cls) + 1]};
    p  = $urandom_range(9, 0);
    if (hi <= lo + 32'd1) return noise_width();
    if (p == 0) return lo + 32'd1;
    if (p == 1) return hi - 32'd1;
    return lo + 32'd1 + $urandom_range(hi - lo - 32'd2, 0);
  endfunction

  // Optional sync, frame_q bytes plus a CRC byte that may be corrupted, loose bits, frame end
  task automatic send_frame(input int tail_bits, input bit bad_crc, input bit skip_sync);
    logic [7:0] crc;
    if (!skip_sync) send_pulse(class_width(CLS_SYNC));
    crc = 8'h00;
    foreach (frame_q[i])
      for (int j = 0; j < 8; j++) crc = crc_step(crc, frame_q[i][j]);
    if (bad_crc) crc = crc ^ (8'h01 << $urandom_range(7, 0));
    frame_q.push_back(crc);
    foreach (frame_q[i])
      for (int j = 0; j < 8; j++) begin
        if ($urandom_range(99, 0) < noise_pct) send_pulse(noise_width());
        send_pulse(class_width(frame_q[i][j] ? CLS_ONE : CLS_ZERO));
      end
    repeat (tail_bits) send_pulse(class_width($urandom_range(1, 0) ? CLS_ONE : CLS_ZERO));
    send_pulse(class_width(CLS_END));
  endtask

  // Stray edges: lone edges of either level and pulses of arbitrary width
  task automatic send_noise(input int n);
    repeat (n) begin
      if ($urandom_range(1, 0)) begin
        pin_clock = pin_clock + $urandom_range(4000, 0);
        send_edge($urandom_range(1, 0), pin_clock);
      end else begin
        send_pulse(noise_width());
      end
    end
  endtask

  // One random frame: mostly well formed, some corrupt, partial or noisy
  task automatic send_random_frame();
    int pick, nbytes, shape;
    pick   = $urandom_range(99, 0);
    nbytes = (pick < 45) ? $urandom_range(3, 0) :
             (pick < 90) ? $urandom_range(14, 4) :
             (pick < 98) ? $urandom_range(30, 15) : $urandom_range(70, 60);
    frame_q.delete();
    repeat (nbytes) begin
      case ($urandom_range(9, 0))
        0:       frame_q.push_back(8'h00);
        1:       frame_q.push_back(8'hFF);
        2:       frame_q.push_back(8'h80);
        3:       frame_q.push_back(8'h7F);
        default: frame_q.push_back($urandom);
      endcase
    end
    shape = $urandom_range(99, 0);
    if (shape < 70)      send_frame(0, 1'b0, $urandom_range(19, 0) == 0);
    else if (shape < 80) send_frame(0, 1'b1, 1'b0);
    else if (shape < 90) send_frame($urandom_range(7, 1), 1'b0, 1'b0);
    else begin
      send_noise($urandom_range(12, 2));
      if ($urandom_range(1, 0)) send_pulse(class_width(CLS_END));
    end
  endtask

  // Stop sending and let every pending result and any edge in flight drain
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_bound(input reg_idx_t idx, input int value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value[BOUND_W-1:0];
    bound[idx] = value[BOUND_W-1:0];
  endtask

  task automatic set_bounds(input int zlo, input int zhi, input int olo, input int ohi,
                            input int slo, input int shi, input int elo, input int ehi);
    write_bound(REG_ZERO_LO, zlo);
    write_bound(REG_ZERO_HI, zhi);
    write_bound(REG_ONE_LO,  olo);
    write_bound(REG_ONE_HI,  ohi);
    write_bound(REG_SYNC_LO, slo);
    write_bound(REG_SYNC_HI, shi);
    write_bound(REG_END_LO,  elo);
    write_bound(REG_END_HI,  ehi);
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  task automatic apply_setting(input setting_t kind);
    int v [8];
    int c, scale;
    case (kind)
      SET_SPREAD: begin
        // disjoint windows in ascending order, sometimes stretched out
        scale = ($urandom_range(3, 0) == 0) ? 8 : 1;
        c = $urandom_range(300, 0);
        for (int k = 0; k < 4; k++) begin
          v[2 * k]     = c;
          v[2 * k + 1] = c + 2 + $urandom_range(400, 0);
          c = v[2 * k + 1] + $urandom_range(300, 0);
        end
        for (int k = 0; k < 8; k++) v[k] = v[k] * scale;
      end
      SET_OVERLAP: begin
        // each window can overlap the next, so priority decides
        v[0] = $urandom_range(300, 0);
        v[1] = v[0] + 200 + $urandom_range(400, 0);
        v[2] = v[0] + $urandom_range(300, 50);
        v[3] = v[1] + $urandom_range(500, 100);
        v[4] = v[3] - $urandom_range(100, 0);
        v[5] = v[4] + $urandom_range(400, 2);
        v[6] = v[4] + $urandom_range(200, 0);
        v[7] = v[5] + $urandom_range(500, 50);
      end
      SET_WIDE: begin
        v = '{0, 3000, 3000, 20000, 20000, 40000, 40000, 65535};
      end
      SET_ZEROS: begin
        v = '{0, 0, 0, 0, 0, 0, 0, 0};
      end
      SET_MAX: begin
        v = '{65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535};
      end
      default: begin
        for (int k = 0; k < 8; k++) v[k] = BOUND_RESET[k];
      end
    endcase
    set_bounds(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
  endtask

  task automatic add_row(input row_kind_t kind, input logic [31:0] t, input logic [31:0] w,
                         input int n);
    dir_row_t row;
    row = '0;
    row.kind = kind;
    row.t = t;
    row.w = w;
    row.n = n;
    dir_rows.push_back(row);
  endtask

  // Row whose frame-end result is written down directly; words are still zero
  task automatic add_typed(input row_kind_t kind, input logic [31:0] t, input logic [31:0] w,
                           input status_t st, input int frames, input int partials,
                           input int crc_bad);
    dir_row_t row;
    row = '0;
    row.kind = kind;
    row.t = t;
    row.w = w;
    row.n = 1;
    row.typed = 1'b1;
    row.res.status   = st;
    row.res.frames   = frames;
    row.res.partials = partials;
    row.res.crc_bad  = crc_bad;
    dir_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Drive the result side's ready at the falling edge
  always @(negedge clk) begin
    if (steady) out_ready = 1'b1;
    else        out_ready = ($urandom_range(99, 0) >= 33);
  end

  // Compare each result transfer with the oldest pending frame result
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_results_due.size() == 0) begin
        $error("result with no frame end pending: status %0d frames %0d",
               out_frame_status, out_frames_seen);
        fail_count++;
      end else begin
        want = frame_results_due.pop_front();
        check_field("frame_status", want.status, out_frame_status);
        check_field("frames_seen", want.frames, out_frames_seen);
        check_field("incomplete_seen", want.partials, out_incomplete_seen);
        check_field("crc_failures", want.crc_bad, out_crc_failures);
        check_field("word_one", $signed(want.words[0]), out_word_one);
        check_field("word_two", $signed(want.words[1]), out_word_two);
        check_field("word_three", $signed(want.words[2]), out_word_three);
        check_field("word_four", $signed(want.words[3]), out_word_four);
        check_field("word_five", $signed(want.words[4]), out_word_five);
      end
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(12 * 1000000);
    $display("tb_pulse_width_frame_decoder failed");
    $finish;
  end

  initial begin
    int rand_start, rand_edges, rand_results, phase_idx, phase_start;
    setting_t kind;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_ZERO_LO;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_pin_level = 1'b0;
    in_edge_time = '0;
    out_ready    = 1'b0;
    steady       = 1'b0;
    noise_pct    = 0;
    typed_pending = 1'b0;
    typed_result = '0;
    edges_sent   = 0;
    results_due_total = 0;
    settings_used = 0;
    fail_count   = 0;
    pin_clock    = '0;

    // Model reset state
    for (int k = 0; k < NUM_REGS; k++) bound[k] = BOUND_RESET[k];
    for (int k = 0; k < BUF_BYTES; k++) frame_buf[k] = 8'h00;
    fall_us = '0;
    bit_idx = '0;
    byte_idx = 0;
    crc_run = '0;
    crc_prior = '0;
    frames_total = '0;
    partial_total = '0;
    crc_bad_total = '0;
    words_held = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table under the reset bounds
    add_typed(ROW_RISE, 32'd3000, 32'd0, ST_INCOMPLETE, 1, 1, 0); // end from time zero, empty
    add_row(ROW_PULSE, 32'd10000, 32'd200, 1);                   // on the zero lower bound
    add_row(ROW_PULSE, 32'd20000, 32'd201, 1);
    add_row(ROW_PULSE, 32'd30000, 32'd399, 1);
    add_row(ROW_PULSE, 32'd40000, 32'd400, 1);
    add_row(ROW_PULSE, 32'd50000, 32'd500, 1);
    add_row(ROW_PULSE, 32'd60000, 32'd501, 1);
    add_row(ROW_PULSE, 32'd70000, 32'd699, 1);
    add_row(ROW_PULSE, 32'd80000, 32'd700, 1);
    add_typed(ROW_PULSE, 32'd90000, 32'd2999, ST_INCOMPLETE, 2, 2, 0); // four loose bits
    add_row(ROW_PULSE, 32'd100000, 32'd2099, 1);                 // sync
    add_row(ROW_PULSE, 32'd110000, 32'd501, 8);                  // byte 0xFF
    add_typed(ROW_PULSE, 32'd200000, 32'd2901, ST_CRC_FAIL, 3, 2, 1);
    add_row(ROW_PULSE, 32'd210000, 32'd1901, 1);                 // sync
    add_row(ROW_PULSE, 32'd220000, 32'd201, 8);                  // byte 0x00
    add_typed(ROW_PULSE, 32'd300000, 32'd3099, ST_ACCEPTED, 4, 2, 1);
    add_row(ROW_FALL, 32'd400000, 32'd0, 1);                     // repeated falls restart
    add_row(ROW_FALL, 32'd401000, 32'd0, 1);
    add_typed(ROW_RISE, 32'd404000, 32'd0, ST_ACCEPTED, 5, 2, 1);
    add_typed(ROW_RISE, 32'd404050, 32'd0, ST_ACCEPTED, 6, 2, 1); // second rise, same fall
    add_row(ROW_PULSE, 32'hFFFF_FE00, 32'd600, 1);               // width across time wrap
    add_typed(ROW_PULSE, 32'd1000, 32'd3000, ST_INCOMPLETE, 7, 3, 1);
    add_row(ROW_FRAME, 32'd500000, 32'h80, 13);                  // words 0x8000
    add_row(ROW_FRAME, 32'd600000, 32'h7F, 13);                  // words 0x7FFF
    add_row(ROW_FRAME, 32'd700000, 32'h100, 13);                 // random contents
    add_row(ROW_FRAME, 32'd800000, 32'h100, 70);                 // overruns the buffer

    foreach (dir_rows[i]) begin
      pin_clock     = dir_rows[i].t;
      typed_pending = dir_rows[i].typed;
      typed_result  = dir_rows[i].res;
      case (dir_rows[i].kind)
        ROW_PULSE: repeat (dir_rows[i].n) send_pulse(dir_rows[i].w);
        ROW_FALL:  send_edge(1'b0, dir_rows[i].t);
        ROW_RISE:  send_edge(1'b1, dir_rows[i].t);
        default: begin
          // fill below 256: even bytes take it, odd bytes the opposite sign fill
          frame_q.delete();
          for (int b = 0; b < dir_rows[i].n; b++)
            if (dir_rows[i].w < 32'd256)
              frame_q.push_back(b[0] ? {8{~dir_rows[i].w[7]}} : dir_rows[i].w[7:0]);
            else
              frame_q.push_back($urandom);
          send_frame(0, 1'b0, 1'b0);
        end
      endcase
      typed_pending = 1'b0;
    end

    // Random frames, one bound setting per phase
    noise_pct    = 3;
    rand_start   = edges_sent;
    rand_results = results_due_total;
    rand_edges   = 0;
    phase_idx    = 0;
    pin_clock    = $urandom;
    while (rand_edges < 1600 || results_due_total - rand_results < 40) begin
      drain_results();
      kind = setting_t'(phase_idx % 6);
      apply_setting(kind);
      steady = (kind == SET_WIDE);
      if (kind == SET_ZEROS || kind == SET_MAX) begin
        send_noise(20);
      end else begin
        phase_start = edges_sent;
        while (edges_sent - phase_start < 500) send_random_frame();
        rand_edges += edges_sent - phase_start;
      end
      steady = 1'b0;
      phase_idx++;
    end

    drain_results();
    $display("covered %0d edges over %0d bound settings (%0d random edges)",
             edges_sent, settings_used, edges_sent - rand_start);
    $display("frame ends: %0d, incomplete %0d, crc errors %0d, accepted %0d",
             frames_total, partial_total, crc_bad_total,
             frames_total - partial_total - crc_bad_total);
    if (fail_count == 0)
      $display("tb_pulse_width_frame_decoder passed");
    else
      $display("tb_pulse_width_frame_decoder failed");
    $finish;
  end

endmodule
